@@ src/ptd_pkg.sv @@
// Shared constants, codes and types of the packed table with duplicate check.
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int DEPTH      = 64;
    localparam int ENTRY_BITS = 32;

    // Fixed field widths of the item and result beats and of the configuration port.
    localparam int ACT_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int OCOUNT_W = 7;
    localparam int CFG_W    = 7;
    localparam int CFGI_W   = 2;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef logic [ENTRY_BITS-1:0] t_entry;
    typedef logic [CNT_W-1:0]      t_count;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_GET    = 2'd2,
        ACT_FIND   = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_BADSLOT  = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [CFGI_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_DEDUP    = 2'd1,
        CFG_GROWTH   = 2'd2
    } t_cfg_idx;

    // Probe that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic   valid;
        logic   hit;
        t_count idx;
        t_entry val;
    } t_lane;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic              wr_en;
        t_entry            wr_val;
        logic              shift_en;
        logic [SLOT_W-1:0] shift_slot;
        logic              get_mode;
        logic [SLOT_W-1:0] slot;
        t_entry            key;
        t_count            count;
    } t_cell_ctl;

endpackage

@@ src/ptd_in_if.sv @@
// Item channel: valid/ready handshake with the action payload.
`timescale 1ns / 1ps

interface ptd_in_if import ptd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot_index;
    logic [VAL_W-1:0]  entry_value;

    modport source (output valid, action, slot_index, entry_value, input ready);
    modport sink   (input valid, action, slot_index, entry_value, output ready);
endinterface

@@ src/ptd_out_if.sv @@
// Result channel: valid/ready handshake with the status payload.
`timescale 1ns / 1ps

interface ptd_out_if import ptd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [SLOT_W-1:0]   result_index;
    logic [VAL_W-1:0]    result_value;
    logic [OCOUNT_W-1:0] count;

    modport source (output valid, status, result_index, result_value, count, input ready);
    modport sink   (input valid, status, result_index, result_value, count, output ready);
endinterface

@@ src/packed_table_with_dedup.sv @@
// Top level: controller, configuration registers and the row of table cells.
`timescale 1ns / 1ps

// Packed table of DEPTH entries held in a row of cells, slots 0 to count-1 with no
// holes. Append (without the duplicate check), remove and any action that fails its
// full or slot check finish at once: they go straight to the result state, and the
// next item can be taken as soon as their result is loaded. Get, find and append
// with reject_duplicates set launch a probe that walks the cell row one cell per
// cycle, so these finish only when the probe leaves the top cell, and the next
// item can again be taken once that result is loaded. One item is in work at a
// time; a finished result sits in the output register, so the next item is taken
// while that result waits. Configuration is written through
// i_cfg_we / i_cfg_index / i_cfg_data; index 3 is ignored.
module packed_table_with_dedup import ptd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ptd_in_if.sink           i_item,
    ptd_out_if.source        o_result,
    input  logic             i_cfg_we,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RES  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_count            r_count, n_count;
    logic [CFG_W-1:0]  r_cap;
    logic              r_dedup, r_growth;
    t_action           r_act, n_act;
    t_entry            r_key, n_key;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_launch, n_launch;
    t_status           r_p_status, n_p_status;
    t_count            r_p_idx, n_p_idx;
    t_entry            r_p_val, n_p_val;

    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic [SLOT_W-1:0]   r_out_idx, n_out_idx;
    logic [VAL_W-1:0]    r_out_val, n_out_val;
    logic [OCOUNT_W-1:0] r_out_count, n_out_count;

    t_cell_ctl w_ctl;
    t_lane     w_lane [DEPTH+1];
    t_entry    w_entry [DEPTH+1];

    logic      w_in_acc, w_full, w_bad, w_load;
    t_action   w_act;
    t_entry    w_val_in;
    logic [CMP_W-1:0] w_cnt_x;

    assign w_in_acc = i_item.valid && i_item.ready;
    assign w_act    = t_action'(i_item.action);
    assign w_val_in = t_entry'(i_item.entry_value);
    assign w_cnt_x  = CMP_W'(r_count);
    assign w_full   = ((w_cnt_x >= CMP_W'(r_cap)) &&
                       !(r_growth && (w_cnt_x < CMP_W'(DEPTH)))) ||
                      (w_cnt_x >= CMP_W'(DEPTH));
    assign w_bad    = CMP_W'(i_item.slot_index) >= w_cnt_x;
    assign w_load   = (r_state == S_RES) && (!r_out_valid || o_result.ready);

    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_act        = r_act;
        n_key        = r_key;
        n_slot       = r_slot;
        n_launch     = 1'b0;
        n_p_status   = r_p_status;
        n_p_idx      = r_p_idx;
        n_p_val      = r_p_val;
        w_ctl.wr_en      = 1'b0;
        w_ctl.wr_val     = w_val_in;
        w_ctl.shift_en   = 1'b0;
        w_ctl.shift_slot = i_item.slot_index;
        w_ctl.get_mode   = (r_act == ACT_GET);
        w_ctl.slot       = r_slot;
        w_ctl.key        = r_key;
        w_ctl.count      = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_act      = w_act;
                    n_key      = w_val_in;
                    n_slot     = i_item.slot_index;
                    n_p_status = ST_OK;
                    n_p_idx    = '0;
                    n_p_val    = '0;
                    n_state    = S_RES;
                    unique case (w_act)
                        ACT_APPEND: begin
                            if (w_full) begin
                                n_p_status = ST_FULL;
                            end else if (r_dedup) begin
                                n_launch = 1'b1;
                                n_state  = S_SCAN;
                            end else begin
                                w_ctl.wr_en = 1'b1;
                                n_p_idx     = r_count;
                                n_count     = r_count + t_count'(1);
                            end
                        end
                        ACT_REMOVE: begin
                            if (w_bad) begin
                                n_p_status = ST_BADSLOT;
                            end else begin
                                w_ctl.shift_en = 1'b1;
                                n_count        = r_count - t_count'(1);
                            end
                        end
                        ACT_GET: begin
                            if (w_bad) begin
                                n_p_status = ST_BADSLOT;
                            end else begin
                                n_launch = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        ACT_FIND: begin
                            n_launch = 1'b1;
                            n_state  = S_SCAN;
                        end
                        default: n_state = S_RES;
                    endcase
                end
            end
            S_SCAN: begin
                // Probe left the top cell: finish the action.
                if (w_lane[DEPTH].valid) begin
                    n_state = S_RES;
                    unique case (r_act)
                        ACT_GET: n_p_val = w_lane[DEPTH].val;
                        ACT_FIND: begin
                            if (w_lane[DEPTH].hit) begin
                                n_p_idx = w_lane[DEPTH].idx;
                            end else begin
                                n_p_status = ST_NOTFOUND;
                            end
                        end
                        ACT_APPEND: begin
                            if (w_lane[DEPTH].hit) begin
                                n_p_status = ST_DUP;
                            end else begin
                                w_ctl.wr_en  = 1'b1;
                                w_ctl.wr_val = r_key;
                                n_p_idx      = r_count;
                                n_count      = r_count + t_count'(1);
                            end
                        end
                        default: n_p_status = ST_OK;
                    endcase
                end
            end
            S_RES: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_val    = r_out_val;
        n_out_count  = r_out_count;
        if (w_load) begin
            n_out_valid  = 1'b1;
            n_out_status = r_p_status;
            n_out_idx    = SLOT_W'(r_p_idx);
            n_out_val    = VAL_W'(r_p_val);
            n_out_count  = OCOUNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CFG_W'(64);
            r_dedup     <= 1'b0;
            r_growth    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CAPACITY: r_cap    <= i_cfg_data;
                    CFG_DEDUP:    r_dedup  <= i_cfg_data[0];
                    CFG_GROWTH:   r_growth <= i_cfg_data[0];
                    default:      r_cap    <= r_cap;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_key        <= n_key;
        r_slot       <= n_slot;
        r_p_status   <= n_p_status;
        r_p_idx      <= n_p_idx;
        r_p_val      <= n_p_val;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_val    <= n_out_val;
        r_out_count  <= n_out_count;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.result_index = r_out_idx;
    assign o_result.result_value = r_out_val;
    assign o_result.count        = r_out_count;

    // Inject a fresh probe at the bottom cell; the top cell sees a cleared neighbor.
    always_comb begin
        w_lane[0]       = '0;
        w_lane[0].valid = r_launch;
    end
    assign w_entry[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ptd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cell_idx   (t_count'(g)),
            .i_ctl        (w_ctl),
            .i_next_entry (w_entry[g+1]),
            .o_entry      (w_entry[g]),
            .i_lane       (w_lane[g]),
            .o_lane       (w_lane[g+1])
        );
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("stored count beyond depth");

    a_probe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane[DEPTH].valid |-> (r_state == S_SCAN))
        else $error("probe left the row outside a scan");

    a_result_from_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RES))
        else $error("result beat raised without a finished action");

    a_launch_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |-> (r_state == S_SCAN))
        else $error("probe launched outside a scan");

endmodule

@@ src/ptd_cell.sv @@
// One table slot: holds an entry, shifts from its upper neighbor, and advances the probe.
`timescale 1ns / 1ps

module ptd_cell import ptd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_count    i_cell_idx,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_next_entry,
    output t_entry    o_entry,
    input  t_lane     i_lane,
    output t_lane     o_lane
);

    t_entry r_entry, n_entry;
    t_lane  r_lane, n_lane;
    logic   w_match;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.wr_en && (i_cell_idx == i_ctl.count)) begin
            n_entry = i_ctl.wr_val;
        end else if (i_ctl.shift_en &&
                     (CMP_W'(i_cell_idx) >= CMP_W'(i_ctl.shift_slot))) begin
            n_entry = i_next_entry;
        end
    end

    always_comb begin
        if (i_ctl.get_mode) begin
            w_match = (CMP_W'(i_cell_idx) == CMP_W'(i_ctl.slot));
        end else begin
            w_match = (i_cell_idx < i_ctl.count) && (r_entry == i_ctl.key);
        end
    end

    // First hit wins; later cells pass the probe on untouched.
    always_comb begin
        n_lane = i_lane;
        if (i_lane.valid && !i_lane.hit && w_match) begin
            n_lane.hit = 1'b1;
            n_lane.idx = i_cell_idx;
            n_lane.val = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_lane  <= '0;
        end else begin
            r_entry <= n_entry;
            r_lane  <= n_lane;
        end
    end

    assign o_entry = r_entry;
    assign o_lane  = r_lane;

endmodule

@@ tb/sv/tb_packed_table_with_dedup.sv @@
// Self-checking testbench of the packed table with duplicate check.
`timescale 1ns / 1ps

module tb_packed_table_with_dedup;
    import ptd_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 228;
    // Watchdog limit for the whole run of about 1850 items, which covers the probe walks
    // plus the stalls and gaps with a wide margin.
    localparam int RUN_LIMIT_CYCLES = 1_000_000;

    localparam logic [CFG_W-1:0] PHASE_CAP    [0:PHASES-1] = '{64, 1, 8, 0, 20, 127, 64, 3};
    localparam bit               PHASE_DEDUP  [0:PHASES-1] = '{0, 1, 1, 0, 1, 0, 1, 0};
    localparam bit               PHASE_GROWTH [0:PHASES-1] = '{0, 0, 0, 1, 1, 0, 1, 0};
    localparam logic [VAL_W-1:0] COMMON_VALS  [0:7] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_0007, 32'h1234_5678
    };

    typedef struct {
        logic [STAT_W-1:0]   status;
        logic [SLOT_W-1:0]   index;
        logic [VAL_W-1:0]    value;
        logic [OCOUNT_W-1:0] count;
    } t_reply;

    // Tracks the table contents and holds the replies still owed by the block.
    class list_tracker;
        t_entry           slots [DEPTH];
        int               fill;
        int               cap_limit;
        bit               dedup;
        bit               growth;
        t_reply           awaited_replies [$];
        int               mismatches;

        function new();
            foreach (slots[i]) slots[i] = '0;
            fill       = 0;
            cap_limit  = 64;
            dedup      = 1'b0;
            growth     = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_CAPACITY: cap_limit = data;
                CFG_DEDUP:    dedup = data[0];
                CFG_GROWTH:   growth = data[0];
                default: ;
            endcase
        endfunction

        function int lowest_match(t_entry v);
            for (int i = 0; i < fill; i++) begin
                if (slots[i] == v) return i;
            end
            return DEPTH;
        endfunction

        // Apply one accepted action and queue the reply it must produce.
        function void apply_action(t_action act, logic [SLOT_W-1:0] slot, logic [VAL_W-1:0] val);
            t_reply r;
            t_entry key;
            int     lim;
            int     hit;
            bit     full;
            key      = t_entry'(val);
            r.status = ST_OK;
            r.index  = '0;
            r.value  = '0;
            case (act)
                ACT_APPEND: begin
                    lim  = (cap_limit > DEPTH) ? DEPTH : cap_limit;
                    full = (fill >= lim);
                    if (full && growth && fill < DEPTH) full = 1'b0;
                    if (fill >= DEPTH) full = 1'b1;
                    if (full) begin
                        r.status = ST_FULL;
                    end else if (dedup && lowest_match(key) < DEPTH) begin
                        r.status = ST_DUP;
                    end else begin
                        slots[fill] = key;
                        r.index = SLOT_W'(fill);
                        fill++;
                    end
                end
                ACT_REMOVE: begin
                    if (slot >= fill) begin
                        r.status = ST_BADSLOT;
                    end else begin
                        for (int i = slot; i + 1 < fill; i++) slots[i] = slots[i + 1];
                        slots[fill - 1] = '0;
                        fill--;
                    end
                end
                ACT_GET: begin
                    if (slot >= fill) r.status = ST_BADSLOT;
                    else r.value = VAL_W'(slots[slot]);
                end
                default: begin
                    hit = lowest_match(key);
                    if (hit >= DEPTH) r.status = ST_NOTFOUND;
                    else r.index = SLOT_W'(hit);
                end
            endcase
            r.count = OCOUNT_W'(fill);
            awaited_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (awaited_replies.size() == 0) begin
                $display("%0t ns: result beat with nothing pending: expected none, got %0d/%0d/0x%0h/%0d",
                         $time, got.status, got.index, got.value, got.count);
                mismatches++;
                return;
            end
            want = awaited_replies.pop_front();
            compare_field("status", VAL_W'(want.status), VAL_W'(got.status));
            compare_field("result_index", VAL_W'(want.index), VAL_W'(got.index));
            compare_field("result_value", want.value, got.value);
            compare_field("count", VAL_W'(want.count), VAL_W'(got.count));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFGI_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    ptd_in_if  item_ch ();
    ptd_out_if result_ch ();

    list_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;

    packed_table_with_dedup u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Offer one item and hold it until the block takes the beat.
    task automatic send_item(t_action act, logic [SLOT_W-1:0] slot, logic [VAL_W-1:0] val);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        item_ch.valid       <= 1'b1;
        item_ch.action      <= act;
        item_ch.slot_index  <= slot;
        item_ch.entry_value <= val;
        do @(posedge i_clk); while (!item_ch.ready);
        tracker.apply_action(act, slot, val);
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(logic [CFG_W-1:0] cap, bit dedup, bit growth);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CAPACITY;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        tracker.set_reg(CFG_CAPACITY, cap);
        i_cfg_index <= CFG_DEDUP;
        i_cfg_data  <= CFG_W'(dedup);
        @(posedge i_clk);
        tracker.set_reg(CFG_DEDUP, CFG_W'(dedup));
        i_cfg_index <= CFG_GROWTH;
        i_cfg_data  <= CFG_W'(growth);
        @(posedge i_clk);
        tracker.set_reg(CFG_GROWTH, CFG_W'(growth));
        i_cfg_we <= 1'b0;
    endtask

    // trend 0 fills the table, 1 mixes, 2 drains it
    function automatic t_action pick_action(int trend);
        int r;
        r = $urandom_range(0, 99);
        case (trend)
            0: begin
                if (r < 60) return ACT_APPEND;
                if (r < 70) return ACT_REMOVE;
                if (r < 85) return ACT_GET;
                return ACT_FIND;
            end
            2: begin
                if (r < 15) return ACT_APPEND;
                if (r < 65) return ACT_REMOVE;
                if (r < 85) return ACT_GET;
                return ACT_FIND;
            end
            default: begin
                if (r < 25) return ACT_APPEND;
                if (r < 50) return ACT_REMOVE;
                if (r < 75) return ACT_GET;
                return ACT_FIND;
            end
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value(t_action act);
        if (act == ACT_FIND && tracker.fill > 0 && $urandom_range(0, 1) == 1)
            return VAL_W'(tracker.slots[$urandom_range(0, tracker.fill - 1)]);
        if ($urandom_range(0, 1) == 1)
            return COMMON_VALS[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        if (tracker.fill > 0 && $urandom_range(0, 99) < 75)
            return SLOT_W'($urandom_range(0, tracker.fill - 1));
        return SLOT_W'($urandom_range(0, DEPTH - 1));
    endfunction

    initial begin : result_sink
        t_reply got;
        int     hold_left;
        int     hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got.status = result_ch.status;
                got.index  = result_ch.result_index;
                got.value  = result_ch.result_value;
                got.count  = result_ch.count;
                tracker.check_reply(got);
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                result_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        t_action act;
        int      trend;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_CAPACITY;
        i_cfg_data          <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.action      <= ACT_APPEND;
        item_ch.slot_index  <= '0;
        item_ch.entry_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: bad slots and a find miss, then appends, finds, gets and a remove
        send_item(ACT_GET, 6'd0, 32'h0);
        send_item(ACT_REMOVE, 6'd63, 32'h0);
        send_item(ACT_FIND, 6'd0, 32'h0);
        send_item(ACT_APPEND, 6'd0, 32'hFFFF_FFFF);
        send_item(ACT_APPEND, 6'd63, 32'h0);
        send_item(ACT_APPEND, 6'd0, 32'hFFFF_FFFF);
        send_item(ACT_FIND, 6'd0, 32'hFFFF_FFFF);
        send_item(ACT_FIND, 6'd0, 32'h0);
        send_item(ACT_FIND, 6'd0, 32'h1234_5678);
        send_item(ACT_GET, 6'd2, 32'h0);
        send_item(ACT_GET, 6'd3, 32'h0);
        send_item(ACT_REMOVE, 6'd0, 32'h0);
        send_item(ACT_GET, 6'd0, 32'h0);
        // remove the last entry, then read the slot it left behind
        send_item(ACT_REMOVE, 6'd1, 32'h0);
        send_item(ACT_GET, 6'd1, 32'h0);

        // zero capacity reports full
        write_config(7'd0, 1'b1, 1'b0);
        send_item(ACT_APPEND, 6'd0, 32'hA5A5_A5A5);
        // full is checked before the duplicate
        write_config(7'd2, 1'b1, 1'b0);
        send_item(ACT_APPEND, 6'd0, 32'h0);
        send_item(ACT_APPEND, 6'd0, 32'h5A5A_5A5A);
        send_item(ACT_APPEND, 6'd0, 32'h0);
        // growth past a zero limit
        write_config(7'd0, 1'b1, 1'b1);
        send_item(ACT_APPEND, 6'd0, 32'h0);
        send_item(ACT_APPEND, 6'd0, 32'h3C3C_3C3C);
        send_item(ACT_REMOVE, 6'd2, 32'h0);
        send_item(ACT_REMOVE, 6'd1, 32'h0);
        send_item(ACT_REMOVE, 6'd0, 32'h0);

        for (int p = 0; p < PHASES; p++) begin
            write_config(PHASE_CAP[p], PHASE_DEDUP[p], PHASE_GROWTH[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            trend = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0 && n != 0) trend = $urandom_range(0, 2);
                // stop the receiver for a long stretch while items keep coming
                if (p == 0 && n == 80) hold_requests <= hold_requests + 1;
                act = pick_action(trend);
                send_item(act, pick_slot(), pick_value(act));
            end
        end

        wait_idle();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.awaited_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/ptd_pkg.sv
src/ptd_in_if.sv
src/ptd_out_if.sv
src/ptd_cell.sv
src/packed_table_with_dedup.sv
tb/sv/tb_packed_table_with_dedup.sv
